// File: src/wers_pkg.sv
// ----------------------------------------------------------------------------
// wers_pkg: shared types and constants
// Widths, codes and the token that walks the stamp cell chain.
// ----------------------------------------------------------------------------
package wers_pkg;

    localparam int RING_DEPTH = 16;
    localparam int TIME_WIDTH = 32;

    localparam int IDX_W   = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W   = $clog2(RING_DEPTH + 1);
    localparam int NUM_W   = $clog2(100 * RING_DEPTH + 1);
    localparam int SCORE_W = 7;
    localparam int HLEN_W  = 5;
    localparam int WIN_W   = 32;
    localparam int CMP_W   = (TIME_WIDTH > WIN_W) ? TIME_WIDTH : WIN_W;
    localparam int CFG_IDX_W = 2;

    localparam logic [1:0] ACT_FAIL  = 2'd0;
    localparam logic [1:0] ACT_FULL  = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_HISTORY_LEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MS   = 2'd1;

    localparam logic [HLEN_W-1:0] HLEN_RESET   = 5'd16;
    localparam logic [WIN_W-1:0]  WINDOW_RESET = 32'd1000;

    typedef logic [TIME_WIDTH-1:0] stamp_t;
    typedef logic [WIN_W-1:0]      win_t;
    typedef logic [CNT_W-1:0]      cnt_t;
    typedef logic [IDX_W-1:0]      idx_t;

    typedef struct packed {
        logic valid;
        cnt_t fail_cnt;
        cnt_t full_cnt;
    } tok_t;

endpackage

// File: src/wers_cell.sv
// ----------------------------------------------------------------------------
// wers_cell: one stamp slot of each ring
// Holds a failure stamp and a full stamp, tests both against the window and
// adds its hits to the count token before handing it to the next cell.
// ----------------------------------------------------------------------------
module wers_cell (
    input  logic             clk,
    input  logic             rst_n,
    input  wers_pkg::stamp_t now,
    input  wers_pkg::win_t   window,
    input  wers_pkg::stamp_t wr_data,
    input  logic             wr_fail,
    input  logic             wr_full,
    input  logic             vld_fail,
    input  logic             vld_full,
    input  wers_pkg::tok_t   tok_in,
    output wers_pkg::tok_t   tok_out
);
    import wers_pkg::*;

    stamp_t fail_stamp_reg;
    stamp_t full_stamp_reg;
    tok_t   tok_reg;
    tok_t   tok_next;
    stamp_t fail_age;
    stamp_t full_age;
    logic   fail_hit;
    logic   full_hit;

    always_ff @(posedge clk)
    begin
        if (wr_fail)
        begin
            fail_stamp_reg <= wr_data;
        end
        if (wr_full)
        begin
            full_stamp_reg <= wr_data;
        end
    end

    // modular age, wraps with the time base
    always_comb
    begin
        fail_age = now - fail_stamp_reg;
        full_age = now - full_stamp_reg;
        fail_hit = vld_fail && (CMP_W'(fail_age) < CMP_W'(window));
        full_hit = vld_full && (CMP_W'(full_age) < CMP_W'(window));
        tok_next.valid    = tok_in.valid;
        tok_next.fail_cnt = tok_in.fail_cnt + CNT_W'(fail_hit);
        tok_next.full_cnt = tok_in.full_cnt + CNT_W'(full_hit);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

// File: src/wers_div.sv
// ----------------------------------------------------------------------------
// wers_div: restoring divider for the percent score
// One quotient bit per cycle; done is raised as the last quotient bit is stored.
// ----------------------------------------------------------------------------
module wers_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [wers_pkg::NUM_W-1:0]    num,
    input  wers_pkg::cnt_t                den,
    output logic                          done,
    output logic [wers_pkg::SCORE_W-1:0]  quo
);
    import wers_pkg::*;

    localparam int STEP_W = $clog2(NUM_W + 1);

    logic              active_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [NUM_W-1:0]  num_reg;
    logic [NUM_W-1:0]  quo_reg;
    cnt_t              rem_reg;
    cnt_t              den_reg;
    logic [CNT_W:0]    trial;
    logic              fits;
    cnt_t              rem_next;

    always_comb
    begin
        trial    = {rem_reg, num_reg[NUM_W-1]};
        fits     = trial >= {1'b0, den_reg};
        rem_next = fits ? CNT_W'(trial - {1'b0, den_reg}) : CNT_W'(trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            step_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                active_reg <= 1'b1;
                step_reg   <= '0;
            end
            else if (active_reg)
            begin
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(NUM_W - 1))
                begin
                    active_reg <= 1'b0;
                    done_reg   <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (active_reg)
        begin
            num_reg <= {num_reg[NUM_W-2:0], 1'b0};
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quo  = SCORE_W'(quo_reg);

endmodule

// File: src/windowed_event_rate_score.sv
// ----------------------------------------------------------------------------
// windowed_event_rate_score: sliding-window failure/full event rate scorer
// Event requests are stored when accepted. For a query the count token walks
// the cell chain, then the dividers.
// One request is in work at a time; the result register frees the input side.
// Reset clears fills, ring pointers and the config to 16 slots, 1000 ms.
// ----------------------------------------------------------------------------
module windowed_event_rate_score (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [1:0]                         action,
    input  logic [31:0]                        time_ms,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [6:0]                         score,
    output logic [6:0]                         fail_rate,
    output logic [6:0]                         full_rate,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [wers_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [31:0]                        cfg_data
);
    import wers_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_HOLD = 2'd3;

    typedef struct packed {
        idx_t slot;
        cnt_t fill;
        idx_t next;
    } rec_t;

    logic [1:0]        state_reg, state_next;
    logic [HLEN_W-1:0] hlen_reg;
    win_t              window_reg;
    stamp_t            now_reg;
    logic              inj_reg;
    cnt_t              fail_fill_reg, full_fill_reg;
    idx_t              fail_next_reg, full_next_reg;
    logic              out_valid_reg;
    logic [6:0]        score_reg, fail_rate_reg, full_rate_reg;

    logic              in_acc;
    logic              rec_fail, rec_full, query;
    stamp_t            now_in;
    cnt_t              eff_len;
    rec_t              fail_rec, full_rec;
    tok_t              chain [RING_DEPTH+1];
    logic              div_start;
    logic              fail_done, full_done;
    logic [6:0]        fail_quo, full_quo;
    logic [6:0]        fail_pct, full_pct;
    logic              load_out;

    function automatic rec_t ring_step(cnt_t fill, idx_t next, cnt_t len);
        rec_t r;
        cnt_t slot_w;
        cnt_t next_w;
        if (fill < len)
        begin
            slot_w = fill;
            r.fill = fill + CNT_W'(1);
        end
        else
        begin
            slot_w = (CNT_W'(next) < len) ? CNT_W'(next) : '0;
            r.fill = fill;
        end
        next_w = slot_w + CNT_W'(1);
        r.slot = IDX_W'(slot_w);
        r.next = (next_w >= len) ? '0 : IDX_W'(next_w);
        return r;
    endfunction

    always_comb
    begin
        if (hlen_reg == '0)
        begin
            eff_len = CNT_W'(1);
        end
        else if (32'(hlen_reg) > RING_DEPTH)
        begin
            eff_len = CNT_W'(RING_DEPTH);
        end
        else
        begin
            eff_len = CNT_W'(hlen_reg);
        end
    end

    assign in_stall = (state_reg != S_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign rec_fail = in_acc && (action == ACT_FAIL);
    assign rec_full = in_acc && (action == ACT_FULL);
    assign query    = in_acc && (action == ACT_QUERY);
    assign now_in   = TIME_WIDTH'(time_ms);
    assign fail_rec = ring_step(fail_fill_reg, fail_next_reg, eff_len);
    assign full_rec = ring_step(full_fill_reg, full_next_reg, eff_len);
    assign cfg_ready = 1'b1;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hlen_reg   <= HLEN_RESET;
            window_reg <= WINDOW_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_HISTORY_LEN: hlen_reg   <= cfg_data[HLEN_W-1:0];
                CFG_WINDOW_MS:   window_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // ring pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fail_fill_reg <= '0;
            fail_next_reg <= '0;
            full_fill_reg <= '0;
            full_next_reg <= '0;
        end
        else
        begin
            if (rec_fail)
            begin
                fail_fill_reg <= fail_rec.fill;
                fail_next_reg <= fail_rec.next;
            end
            if (rec_full)
            begin
                full_fill_reg <= full_rec.fill;
                full_next_reg <= full_rec.next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (query)
        begin
            now_reg <= now_in;
        end
    end

    // cell chain: inject an empty token, collect the counts at the far end
    assign chain[0].valid    = inj_reg;
    assign chain[0].fail_cnt = '0;
    assign chain[0].full_cnt = '0;

    for (genvar gi = 0; gi < RING_DEPTH; gi++)
    begin : g_cell
        wers_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .now      (now_reg),
            .window   (window_reg),
            .wr_data  (now_in),
            .wr_fail  (rec_fail && (fail_rec.slot == IDX_W'(gi))),
            .wr_full  (rec_full && (full_rec.slot == IDX_W'(gi))),
            .vld_fail (CNT_W'(gi) < fail_fill_reg),
            .vld_full (CNT_W'(gi) < full_fill_reg),
            .tok_in   (chain[gi]),
            .tok_out  (chain[gi+1])
        );
    end

    assign div_start = (state_reg == S_SCAN) && chain[RING_DEPTH].valid;

    wers_div u_div_fail (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (NUM_W'(chain[RING_DEPTH].fail_cnt) * NUM_W'(100)),
        .den   (fail_fill_reg),
        .done  (fail_done),
        .quo   (fail_quo)
    );

    wers_div u_div_full (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (NUM_W'(chain[RING_DEPTH].full_cnt) * NUM_W'(100)),
        .den   (full_fill_reg),
        .done  (full_done),
        .quo   (full_quo)
    );

    assign fail_pct = (fail_fill_reg == '0) ? '0 : fail_quo;
    assign full_pct = (full_fill_reg == '0) ? '0 : full_quo;
    assign load_out = (state_reg == S_HOLD) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (query) state_next = S_SCAN;
            S_SCAN: if (chain[RING_DEPTH].valid) state_next = S_DIV;
            S_DIV:  if (fail_done && full_done) state_next = S_HOLD;
            S_HOLD: if (load_out) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            inj_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            inj_reg   <= query;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // hold the result until the consumer takes it
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            fail_rate_reg <= fail_pct;
            full_rate_reg <= full_pct;
            score_reg     <= (fail_pct > full_pct) ? fail_pct : full_pct;
        end
    end

    assign out_valid = out_valid_reg;
    assign score     = score_reg;
    assign fail_rate = fail_rate_reg;
    assign full_rate = full_rate_reg;

`ifndef NO_ASSERTIONS
    a_out_from_hold: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_HOLD))
        else $error("result raised outside hold state");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(fail_fill_reg) <= RING_DEPTH) && (32'(full_fill_reg) <= RING_DEPTH))
        else $error("ring fill beyond depth");

    a_token_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        chain[RING_DEPTH].valid |-> (state_reg == S_SCAN))
        else $error("count token left chain outside scan");

    a_dividers_agree: assert property (@(posedge clk) disable iff (!rst_n)
        fail_done == full_done)
        else $error("dividers out of step");

    a_score_is_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((score_reg == fail_rate_reg) || (score_reg == full_rate_reg))
                          && (score_reg >= fail_rate_reg) && (score_reg >= full_rate_reg))
        else $error("score is not the maximum");
`endif

endmodule
